FILE: design/mfp_pkg.sv
`default_nettype none
package mfp_pkg;

  typedef enum logic [2:0] {
    CMD_READ  = 3'd0,
    CMD_WRITE = 3'd1,
    CMD_INPUT = 3'd2,
    CMD_IRQ   = 3'd3,
    CMD_ACK   = 3'd4
  } cmd_e;

  localparam logic [5:0] OFF_GPIP = 6'h01;
  localparam logic [5:0] OFF_AER  = 6'h03;
  localparam logic [5:0] OFF_DDR  = 6'h05;
  localparam logic [5:0] OFF_IERA = 6'h07;
  localparam logic [5:0] OFF_IERB = 6'h09;
  localparam logic [5:0] OFF_IPRA = 6'h0B;
  localparam logic [5:0] OFF_IPRB = 6'h0D;
  localparam logic [5:0] OFF_ISRA = 6'h0F;
  localparam logic [5:0] OFF_ISRB = 6'h11;
  localparam logic [5:0] OFF_IMRA = 6'h13;
  localparam logic [5:0] OFF_IMRB = 6'h15;
  localparam logic [5:0] OFF_VR   = 6'h17;
  localparam logic [5:0] OFF_TACR = 6'h19;
  localparam logic [5:0] OFF_TBCR = 6'h1B;
  localparam logic [5:0] OFF_TCDCR = 6'h1D;
  localparam logic [5:0] OFF_TADR = 6'h1F;
  localparam logic [5:0] OFF_TBDR = 6'h21;
  localparam logic [5:0] OFF_TCDR = 6'h23;
  localparam logic [5:0] OFF_TDDR = 6'h25;
  localparam logic [5:0] OFF_TSR  = 6'h2D;

  localparam logic [7:0] IPRA_READ = 8'h20;
  localparam logic [7:0] TSR_READ  = 8'h80;
  localparam logic [7:0] GPIP_HIDE = 8'h21;
  localparam logic [3:0] TIMER_C_LEVEL = 4'd5;

  typedef struct packed {
    logic [2:0] command;
    logic [5:0] reg_offset;
    logic [7:0] write_data;
    logic [7:0] gpip_mask;
    logic [3:0] irq_level;
    logic [7:0] irq_count;
    logic       printer_busy;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] vector;
    logic       irq_line;
  } result_t;

  // input line to interrupt level
  function automatic logic [3:0] line_level(input logic [2:0] j);
    logic [3:0] r;
    case (j)
      3'd0: r = 4'd0;
      3'd1: r = 4'd1;
      3'd2: r = 4'd2;
      3'd3: r = 4'd3;
      3'd4: r = 4'd6;
      3'd5: r = 4'd7;
      3'd6: r = 4'd14;
      default: r = 4'd15;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: design/mfp_if.sv
`default_nettype none
interface mfp_in_if;
  import mfp_pkg::*;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [5:0] reg_offset;
  logic [7:0] write_data;
  logic [7:0] gpip_mask;
  logic [3:0] irq_level;
  logic [7:0] irq_count;
  logic       printer_busy;
  modport source (output valid, command, reg_offset, write_data, gpip_mask, irq_level,
                  irq_count, printer_busy, input ready);
  modport sink (input valid, command, reg_offset, write_data, gpip_mask, irq_level,
                irq_count, printer_busy, output ready);
endinterface

interface mfp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic [7:0] vector;
  logic       irq_line;
  modport source (output valid, read_data, vector, irq_line, input ready);
  modport sink (input valid, read_data, vector, irq_line, output ready);
endinterface
`default_nettype wire

FILE: design/mfp_core.sv
`default_nettype none
module mfp_core import mfp_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    fire_i,
  input  wire item_t   item_i,
  output result_t      res_o
);

  logic [7:0]  inl_q, inl_d, pdr_q, pdr_d, aer_q, aer_d, ddr_q, ddr_d, vr_q, vr_d;
  logic [15:0] ier_q, ier_d, ipr_q, ipr_d, isr_q, isr_d, imr_q, imr_d;
  logic [15:0] tcr_q, tcr_d;
  logic        line_q, line_d;
  logic [3:0]  ctl_q [4];
  logic [3:0]  ctl_d [4];
  logic [3:0]  flg_q, flg_d;
  logic [7:0]  start_q [4];
  logic [7:0]  start_d [4];
  logic [7:0]  cur_q [4];
  logic [7:0]  cur_d [4];

  logic [15:0] req, en_req, newp, active, top_bit;
  logic [7:0]  old_pdr, m, chg, v;
  logic [7:0]  rd;
  logic [7:0]  vec;
  logic [3:0]  top_lvl;
  logic        found;
  logic [16:0] csum;
  logic [1:0]  t;

  always_comb begin
    inl_d = inl_q; pdr_d = pdr_q; aer_d = aer_q; ddr_d = ddr_q; vr_d = vr_q;
    ier_d = ier_q; ipr_d = ipr_q; isr_d = isr_q; imr_d = imr_q; tcr_d = tcr_q;
    line_d = line_q; flg_d = flg_q;
    ctl_d = ctl_q; start_d = start_q; cur_d = cur_q;
    req = '0; rd = '0; vec = '0; old_pdr = pdr_q; m = '0; chg = '0;
    v = item_i.write_data;
    csum = '0; t = '0;
    active = ipr_q & imr_q;
    found = 1'b0; top_lvl = '0; top_bit = '0;
    for (int i = 0; i < 16; i++) begin
      if (active[i]) begin
        found = 1'b1;
        top_lvl = 4'(i);
      end
    end
    top_bit = 16'(1) << top_lvl;

    case (item_i.command)
      CMD_READ: begin
        unique case (item_i.reg_offset)
          OFF_GPIP: rd = (pdr_q & ~GPIP_HIDE) | {7'd0, item_i.printer_busy};
          OFF_AER:  rd = aer_q;
          OFF_DDR:  rd = ddr_q;
          OFF_IERA: rd = ier_q[15:8];
          OFF_IERB: rd = ier_q[7:0];
          OFF_IPRA: rd = IPRA_READ;
          OFF_IPRB: rd = ipr_q[7:0];
          OFF_ISRA: rd = isr_q[15:8];
          OFF_ISRB: rd = isr_q[7:0];
          OFF_IMRA: rd = imr_q[15:8];
          OFF_IMRB: rd = imr_q[7:0];
          OFF_VR:   rd = vr_q;
          OFF_TACR: rd = {2'd0, flg_q[0], 1'b0, ctl_q[0]};
          OFF_TBCR: rd = {2'd0, flg_q[1], 1'b0, ctl_q[1]};
          OFF_TCDCR: rd = {ctl_q[2][3:2], ctl_q[2][1] | flg_q[3], ctl_q[2][0], ctl_q[3]};
          OFF_TADR, OFF_TBDR, OFF_TCDR, OFF_TDDR: begin
            t = 2'(item_i.reg_offset[4:1] - 4'hF);
            if (ctl_q[t] != '0 && cur_q[t] > 8'd2) cur_d[t] = cur_q[t] - 8'd1;
            rd = cur_d[t];
          end
          OFF_TSR:  rd = TSR_READ;
          default:  rd = '0;
        endcase
      end
      CMD_WRITE: begin
        unique case (item_i.reg_offset)
          OFF_GPIP: pdr_d = (pdr_q & ~ddr_q) | (v & ddr_q);
          OFF_AER: begin
            for (int j = 0; j < 8; j++) begin
              if ((aer_q[j] ^ v[j]) && !ddr_q[j] && (aer_q[j] != inl_q[j]))
                req[line_level(3'(j))] = 1'b1;
            end
            aer_d = v;
          end
          OFF_DDR: begin
            ddr_d = v;
            pdr_d = (pdr_q & v) | (inl_q & ~v);
          end
          OFF_IERA: begin
            ier_d = {v, ier_q[7:0]};
            ipr_d = ipr_q & ier_d;
          end
          OFF_IERB: begin
            ier_d = {ier_q[15:8], v};
            ipr_d = ipr_q & ier_d;
          end
          OFF_IPRA: begin
            ipr_d = ipr_q & {v, 8'hFF};
            if ((ipr_d & imr_q) == '0) line_d = 1'b0;
          end
          OFF_IPRB: begin
            ipr_d = ipr_q & {8'hFF, v};
            if ((ipr_d & imr_q) == '0) line_d = 1'b0;
          end
          OFF_ISRA: begin
            isr_d = isr_q & {v, 8'hFF};
            if (active != '0) line_d = 1'b1;
          end
          OFF_ISRB: begin
            isr_d = isr_q & {8'hFF, v};
            if (active != '0) line_d = 1'b1;
          end
          OFF_IMRA: begin
            imr_d = {v, imr_q[7:0]};
            line_d = (ipr_q & imr_d) != '0;
          end
          OFF_IMRB: begin
            imr_d = {imr_q[15:8], v};
            line_d = (ipr_q & imr_d) != '0;
          end
          OFF_VR: begin
            vr_d = v;
            if (!v[3]) begin
              isr_d = '0;
              line_d = active != '0;
            end
          end
          OFF_TACR: begin
            ctl_d[0] = v[3:0];
            if (v[4]) flg_d[0] = 1'b0;
          end
          OFF_TBCR: begin
            ctl_d[1] = v[3:0];
            if (v[4]) flg_d[1] = 1'b0;
          end
          OFF_TCDCR: begin
            ctl_d[2] = v[7:4];
            ctl_d[3] = v[3:0];
          end
          OFF_TADR, OFF_TBDR, OFF_TCDR, OFF_TDDR: begin
            t = 2'(item_i.reg_offset[4:1] - 4'hF);
            start_d[t] = v;
            if (ctl_q[t] == '0) cur_d[t] = v;
          end
          default: ;
        endcase
      end
      CMD_INPUT: begin
        m = item_i.gpip_mask;
        inl_d = (inl_q & ~m) | (v & m);
        m = m & ~ddr_q;
        pdr_d = (pdr_q & ~m) | (v & m);
        chg = old_pdr ^ pdr_d;
        for (int j = 0; j < 8; j++) begin
          if (chg[j] && (aer_q[j] ? !old_pdr[j] : !pdr_d[j]))
            req[line_level(3'(j))] = 1'b1;
        end
      end
      CMD_IRQ: begin
        // timer c restarts whether or not its level is enabled
        if (item_i.irq_level == TIMER_C_LEVEL && ctl_q[2] != '0) begin
          flg_d[2] = 1'b1;
          cur_d[2] = start_q[2];
        end
        req[item_i.irq_level] = 1'b1;
        if (item_i.irq_level == TIMER_C_LEVEL && ier_q[TIMER_C_LEVEL]) begin
          csum = {1'b0, tcr_q} + {9'd0, item_i.irq_count};
          tcr_d = csum[16] ? 16'hFFFF : csum[15:0];
        end
      end
      CMD_ACK: begin
        if (!found || isr_q >= top_bit) begin
          line_d = 1'b0;
        end else begin
          vec = {vr_q[7:4], top_lvl};
          if (top_lvl == TIMER_C_LEVEL && tcr_q != '0) tcr_d = tcr_q - 16'd1;
          if (top_lvl != TIMER_C_LEVEL || tcr_d == '0) begin
            ipr_d = ipr_q & ~top_bit;
            line_d = 1'b0;
          end
          if (vr_q[3]) isr_d = isr_q | top_bit;
          else if ((ipr_d & imr_q) != '0) line_d = 1'b1;
        end
      end
      default: ;
    endcase

    // requests from input edges, edge register writes or the request command, all on distinct levels
    en_req = req & ier_q;
    newp = en_req & ~ipr_q;
    ipr_d = ipr_d | en_req;
    for (int b = 0; b < 16; b++) begin
      if (newp[b] && imr_q[b] && !(isr_q > (16'(1) << b))) line_d = 1'b1;
    end
  end

  assign res_o = '{read_data: rd, vector: vec, irq_line: line_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inl_q <= 8'hFF; pdr_q <= 8'hFF; aer_q <= '0; ddr_q <= '0; vr_q <= '0;
      ier_q <= '0; ipr_q <= '0; isr_q <= '0; imr_q <= '0; tcr_q <= '0;
      line_q <= 1'b0; flg_q <= '0;
      for (int i = 0; i < 4; i++) begin
        ctl_q[i] <= '0; start_q[i] <= '0; cur_q[i] <= '0;
      end
    end else if (fire_i) begin
      inl_q <= inl_d; pdr_q <= pdr_d; aer_q <= aer_d; ddr_q <= ddr_d; vr_q <= vr_d;
      ier_q <= ier_d; ipr_q <= ipr_d; isr_q <= isr_d; imr_q <= imr_d; tcr_q <= tcr_d;
      line_q <= line_d; flg_q <= flg_d;
      ctl_q <= ctl_d; start_q <= start_d; cur_q <= cur_d;
    end
  end

endmodule
`default_nettype wire

FILE: design/mfp_interrupt_and_port_controller_unit.sv
// channel  | dir | handshake   | payload
// in_i     | in  | valid/ready | command, reg_offset, write_data, gpip_mask, irq_level,
//          |     |             | irq_count, printer_busy
// out_o    | out | valid/ready | read_data, vector, irq_line
// an item is captured in the input register, processed against the register file
// and its result lands in the output register; one item per cycle is sustained
// while the output does not stall. reset clears both valid flags and core state,
// not item_q or res_q. a stalled output holds the input register, dropping in_i.ready.
`default_nettype none
module mfp_interrupt_and_port_controller_unit import mfp_pkg::*; (
  input wire logic clk_i,
  input wire logic rst_ni,
  mfp_in_if.sink   in_i,
  mfp_out_if.source out_o
);

  logic    in_valid_q, out_valid_q, fire;
  item_t   item_q;
  result_t res, res_q;

  assign fire = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) in_valid_q <= in_i.valid;
      if (fire) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      item_q <= '{command: in_i.command, reg_offset: in_i.reg_offset,
                  write_data: in_i.write_data, gpip_mask: in_i.gpip_mask,
                  irq_level: in_i.irq_level, irq_count: in_i.irq_count,
                  printer_busy: in_i.printer_busy};
    end
    if (fire) res_q <= res;
  end

  mfp_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (item_q),
    .res_o  (res)
  );

  assign out_o.valid     = out_valid_q;
  assign out_o.read_data = res_q.read_data;
  assign out_o.vector    = res_q.vector;
  assign out_o.irq_line  = res_q.irq_line;

endmodule
`default_nettype wire

FILE: dv/mfp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module mfp_checker import mfp_pkg::*; (
  input wire logic clk_i,
  input wire logic rst_ni,
  mfp_in_if.sink   in_i,
  mfp_out_if.sink  out_o,
  output int       fail_count_o,
  output int       pending_count_o,
  output int       result_count_o
);

  logic [7:0]  inp_lv, pdat, aer, ddr, vr;
  logic [15:0] ier, ipr, isr, imr, tc_reqs;
  logic [3:0]  tctl [4];
  logic        tflg [4];
  logic [7:0]  tstart [4], tcur [4];
  logic        line;
  result_t     results_q [$];

  function automatic logic [3:0] lvl_of(input int j);
    logic [3:0] r;
    case (j)
      0: r = 4'd0;
      1: r = 4'd1;
      2: r = 4'd2;
      3: r = 4'd3;
      4: r = 4'd6;
      5: r = 4'd7;
      6: r = 4'd14;
      default: r = 4'd15;
    endcase
    return r;
  endfunction

  task automatic raise_irq(input logic [3:0] lvl, input logic [7:0] cnt);
    logic [15:0] b;
    logic [16:0] s;
    b = 16'd1 << lvl;
    if (lvl == TIMER_C_LEVEL && tctl[2] != 0) begin
      tflg[2] = 1'b1;
      tcur[2] = tstart[2];
    end
    if ((ier & b) == 0) return;
    if (lvl == TIMER_C_LEVEL) begin
      s = {1'b0, tc_reqs} + {9'd0, cnt};
      tc_reqs = s[16] ? 16'hFFFF : s[15:0];
    end
    if (ipr & b) return;
    ipr |= b;
    if (!(imr & b)) return;
    if (isr > b) return;
    line = 1'b1;
  endtask

  function automatic logic [7:0] ctl_rd(input int t);
    return {2'b0, tflg[t], 1'b0, tctl[t]};
  endfunction

  task automatic ctl_wr(input int t, input logic [7:0] v);
    tctl[t] = v[3:0];
    if (v[4]) tflg[t] = 1'b0;
  endtask

  task automatic dat_rd(input int t, output logic [7:0] r);
    if (tctl[t] != 0 && tcur[t] > 8'd2) tcur[t] = tcur[t] - 8'd1;
    r = tcur[t];
  endtask

  task automatic reg_rd(input logic [5:0] off, input logic busy, output logic [7:0] r);
    logic [7:0] c2, c3;
    r = '0;
    case (off)
      OFF_GPIP: r = (pdat & ~GPIP_HIDE) | {7'b0, busy};
      OFF_AER:  r = aer;
      OFF_DDR:  r = ddr;
      OFF_IERA: r = ier[15:8];
      OFF_IERB: r = ier[7:0];
      OFF_IPRA: r = IPRA_READ;
      OFF_IPRB: r = ipr[7:0];
      OFF_ISRA: r = isr[15:8];
      OFF_ISRB: r = isr[7:0];
      OFF_IMRA: r = imr[15:8];
      OFF_IMRB: r = imr[7:0];
      OFF_VR:   r = vr;
      OFF_TACR: r = ctl_rd(0);
      OFF_TBCR: r = ctl_rd(1);
      OFF_TCDCR: begin
        c2 = ctl_rd(2);
        c3 = ctl_rd(3);
        r = (c2 << 4) | c3;
      end
      OFF_TADR: dat_rd(0, r);
      OFF_TBDR: dat_rd(1, r);
      OFF_TCDR: dat_rd(2, r);
      OFF_TDDR: dat_rd(3, r);
      OFF_TSR:  r = TSR_READ;
      default:  r = '0;
    endcase
  endtask

  task automatic dat_wr(input int t, input logic [7:0] v);
    tstart[t] = v;
    if (tctl[t] == 0) tcur[t] = v;
  endtask

  task automatic reg_wr(input logic [5:0] off, input logic [7:0] v);
    case (off)
      OFF_GPIP: pdat = (pdat & ~ddr) | (v & ddr);
      OFF_AER: begin
        for (int j = 0; j < 8; j++)
          if ((aer[j] ^ v[j]) && !ddr[j] && (aer[j] != inp_lv[j])) raise_irq(lvl_of(j), 8'd1);
        aer = v;
      end
      OFF_DDR: begin
        ddr = v;
        pdat = (pdat & ddr) | (inp_lv & ~ddr);
      end
      OFF_IERA: begin ier[15:8] = v; ipr &= ier; end
      OFF_IERB: begin ier[7:0] = v; ipr &= ier; end
      OFF_IPRA: begin ipr &= {v, 8'hFF}; if ((ipr & imr) == 0) line = 1'b0; end
      OFF_IPRB: begin ipr &= {8'hFF, v}; if ((ipr & imr) == 0) line = 1'b0; end
      OFF_ISRA: begin isr &= {v, 8'hFF}; if (ipr & imr) line = 1'b1; end
      OFF_ISRB: begin isr &= {8'hFF, v}; if (ipr & imr) line = 1'b1; end
      OFF_IMRA: begin imr[15:8] = v; line = (ipr & imr) != 0; end
      OFF_IMRB: begin imr[7:0] = v; line = (ipr & imr) != 0; end
      OFF_VR: begin
        vr = v;
        if (!v[3]) begin
          isr = '0;
          line = (ipr & imr) != 0;
        end
      end
      OFF_TACR: ctl_wr(0, v);
      OFF_TBCR: ctl_wr(1, v);
      OFF_TCDCR: begin ctl_wr(2, {4'b0, v[7:4]}); ctl_wr(3, {4'b0, v[3:0]}); end
      OFF_TADR: dat_wr(0, v);
      OFF_TBDR: dat_wr(1, v);
      OFF_TCDR: dat_wr(2, v);
      OFF_TDDR: dat_wr(3, v);
      default: ;
    endcase
  endtask

  task automatic set_lines(input logic [7:0] lv, input logic [7:0] m);
    logic [7:0] old;
    old = pdat;
    inp_lv = (inp_lv & ~m) | (lv & m);
    m &= ~ddr;
    pdat = (pdat & ~m) | (lv & m);
    for (int j = 0; j < 8; j++) begin
      if (!(old[j] ^ pdat[j])) continue;
      if (aer[j]) begin if (old[j]) continue; end
      else begin if (pdat[j]) continue; end
      raise_irq(lvl_of(j), 8'd1);
    end
  endtask

  task automatic ack(output logic [7:0] vec);
    logic [15:0] act, b;
    logic [3:0]  lv;
    act = ipr & imr;
    b = '0;
    lv = '0;
    vec = '0;
    for (int j = 15; j >= 0; j--)
      if (act[j]) begin b = 16'd1 << j; lv = j[3:0]; break; end
    if (b == 0 || isr >= b) begin line = 1'b0; return; end
    vec = (vr & 8'hF0) + lv;
    if (lv == TIMER_C_LEVEL && tc_reqs != 0) tc_reqs--;
    if (lv != TIMER_C_LEVEL || tc_reqs == 0) begin
      ipr &= ~b;
      line = 1'b0;
    end
    if (vr[3]) isr |= b;
    else if (ipr & imr) line = 1'b1;
  endtask

  task automatic predict_step(input item_t it);
    result_t r;
    r = '0;
    case (it.command)
      CMD_READ:  reg_rd(it.reg_offset, it.printer_busy, r.read_data);
      CMD_WRITE: reg_wr(it.reg_offset, it.write_data);
      CMD_INPUT: set_lines(it.write_data, it.gpip_mask);
      CMD_IRQ:   raise_irq(it.irq_level, it.irq_count);
      CMD_ACK:   ack(r.vector);
      default: ;
    endcase
    r.irq_line = line;
    results_q.push_back(r);
  endtask

  always_ff @(posedge clk_i or negedge rst_ni) begin
    item_t   it;
    result_t e;
    int      nerr;
    if (!rst_ni) begin
      inp_lv = 8'hFF; pdat = 8'hFF; aer = '0; ddr = '0; vr = '0;
      ier = '0; ipr = '0; isr = '0; imr = '0; tc_reqs = '0; line = 1'b0;
      for (int t = 0; t < 4; t++) begin
        tctl[t] = '0; tflg[t] = 1'b0; tstart[t] = '0; tcur[t] = '0;
      end
      results_q.delete();
      fail_count_o <= 0;
      result_count_o <= 0;
    end else begin
      nerr = 0;
      if (out_o.valid && out_o.ready) begin
        result_count_o <= result_count_o + 1;
        if (results_q.size() == 0) begin
          $error("result with nothing expected");
          nerr++;
        end else begin
          e = results_q.pop_front();
          if (out_o.read_data !== e.read_data) begin
            $error("read_data expected %h got %h", e.read_data, out_o.read_data);
            nerr++;
          end
          if (out_o.vector !== e.vector) begin
            $error("vector expected %h got %h", e.vector, out_o.vector);
            nerr++;
          end
          if (out_o.irq_line !== e.irq_line) begin
            $error("irq_line expected %b got %b", e.irq_line, out_o.irq_line);
            nerr++;
          end
        end
      end
      if (nerr != 0) fail_count_o <= fail_count_o + nerr;
      if (in_i.valid && in_i.ready) begin
        it = '{in_i.command, in_i.reg_offset, in_i.write_data, in_i.gpip_mask,
               in_i.irq_level, in_i.irq_count, in_i.printer_busy};
        predict_step(it);
      end
    end
  end

  assign pending_count_o = results_q.size();

endmodule
`default_nettype wire

FILE: dv/mfp_interrupt_and_port_controller_unit_tb.sv
`timescale 1ns / 1ps
`default_nettype none
module mfp_interrupt_and_port_controller_unit_tb;
  import mfp_pkg::*;

  localparam int LIMIT = 200000;

  logic clk_i, rst_ni;
  int   fails, waiting, seen, cycles, send_idle, recv_idle, hold_off;

  mfp_in_if  in_ch ();
  mfp_out_if out_ch ();

  mfp_interrupt_and_port_controller_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch.sink), .out_o(out_ch.source)
  );

  mfp_checker chk (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch.sink), .out_o(out_ch.sink),
    .fail_count_o(fails), .pending_count_o(waiting), .result_count_o(seen)
  );

  localparam logic [5:0] REG_OFFS [20] = '{OFF_GPIP, OFF_AER, OFF_DDR, OFF_IERA, OFF_IERB,
    OFF_IPRA, OFF_IPRB, OFF_ISRA, OFF_ISRB, OFF_IMRA, OFF_IMRB, OFF_VR, OFF_TACR, OFF_TBCR,
    OFF_TCDCR, OFF_TADR, OFF_TBDR, OFF_TCDR, OFF_TDDR, OFF_TSR};

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver: random stalls plus a long hold-off when asked
  always @(negedge clk_i) begin
    if (!rst_ni) out_ch.ready <= 1'b0;
    else if (hold_off > 0) begin
      out_ch.ready <= 1'b0;
      hold_off <= hold_off - 1;
    end else out_ch.ready <= ($urandom_range(99) >= recv_idle);
  end

  // valid stays up between items sent back to back
  task automatic send(input item_t it);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    {in_ch.command, in_ch.reg_offset, in_ch.write_data, in_ch.gpip_mask,
     in_ch.irq_level, in_ch.irq_count, in_ch.printer_busy} <= it;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic item_t mk(input cmd_e c, input logic [5:0] off, input logic [7:0] d);
    item_t it;
    it = item_t'($urandom);
    it.irq_count = 8'($urandom_range(255, 1));
    it.command = c;
    it.reg_offset = off;
    it.write_data = d;
    return it;
  endfunction

  function automatic item_t rnd_item();
    item_t it;
    int p;
    p = $urandom_range(99);
    if (p < 3) begin
      it = mk(CMD_READ, 6'($urandom), 8'($urandom));
      it.command = 3'($urandom_range(7, 5));
    end else if (p < 25) it = mk(CMD_READ, REG_OFFS[$urandom_range(19)], 8'($urandom));
    else if (p < 45) begin
      it = mk(CMD_WRITE, REG_OFFS[$urandom_range(19)], 8'($urandom));
      // keep software end-of-interrupt mode around more often
      if (it.reg_offset == OFF_VR && $urandom_range(1)) it.write_data[3] = 1'b1;
    end else if (p < 48) it = mk(CMD_WRITE, 6'($urandom), 8'($urandom));
    else if (p < 65) it = mk(CMD_INPUT, '0, 8'($urandom));
    else if (p < 82) begin
      it = mk(CMD_IRQ, '0, '0);
      if ($urandom_range(2) == 0) it.irq_level = TIMER_C_LEVEL;
      if ($urandom_range(9) == 0) it.irq_count = 8'hFF;
    end else it = mk(CMD_ACK, '0, '0);
    return it;
  endfunction

  initial begin
    item_t it;
    rst_ni = 1'b0;
    cycles = 0;
    hold_off = 0;
    send_idle = 0;
    recv_idle = 0;
    in_ch.valid = 1'b0;
    {in_ch.command, in_ch.reg_offset, in_ch.write_data, in_ch.gpip_mask,
     in_ch.irq_level, in_ch.irq_count, in_ch.printer_busy} = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: enable and unmask everything, edges, timers, acknowledges
    send_idle = 15; recv_idle = 60;
    send(mk(CMD_WRITE, OFF_IERA, 8'hFF));
    send(mk(CMD_WRITE, OFF_IERB, 8'hFF));
    send(mk(CMD_WRITE, OFF_IMRA, 8'hFF));
    send(mk(CMD_WRITE, OFF_IMRB, 8'hFF));
    send(mk(CMD_WRITE, OFF_VR, 8'hF8));
    send(mk(CMD_WRITE, OFF_TCDCR, 8'h57));
    send(mk(CMD_WRITE, OFF_TCDR, 8'h40));
    it = mk(CMD_IRQ, '0, '0); it.irq_level = TIMER_C_LEVEL; it.irq_count = 8'hFF;
    send(it);
    for (int k = 0; k < 260; k++) send(it);
    send(mk(CMD_ACK, '0, '0));
    send(mk(CMD_ACK, '0, '0));
    it = mk(CMD_INPUT, '0, 8'h00); it.gpip_mask = 8'hFF;
    send(it);
    send(mk(CMD_WRITE, OFF_AER, 8'hFF));
    send(mk(CMD_READ, OFF_GPIP, '0));
    send(mk(CMD_READ, OFF_TCDR, '0));
    send(mk(CMD_READ, OFF_TCDCR, '0));
    send(mk(CMD_READ, OFF_IPRA, '0));
    send(mk(CMD_READ, OFF_TSR, '0));
    send(mk(CMD_READ, 6'h3F, '0));
    send(mk(CMD_WRITE, 6'h3F, 8'hFF));
    send(mk(CMD_ACK, '0, '0));
    send(mk(CMD_WRITE, OFF_ISRA, 8'h00));
    send(mk(CMD_WRITE, OFF_VR, 8'h00));
    send(mk(CMD_WRITE, OFF_DDR, 8'hFF));

    for (int phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 15 : (phase == 1) ? 60 : 0;
      recv_idle = (phase == 0) ? 60 : (phase == 1) ? 15 : 0;
      if (phase == 2) hold_off <= 300;
      repeat (120) send(rnd_item());
    end
    in_ch.valid <= 1'b0;

    while (waiting != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("ran timer C counter saturation, edge and direction changes, both eoi modes");
    $display("%0d results checked across three stall profiles and a long output hold-off",
             seen);
    if (fails == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
`default_nettype wire
